// ===== src/assert_macros.svh =====
// Assertion macros shared by the list RTL.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at each clock edge, not during reset.
`define ILIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check prop at each clock edge, reset included.
`define ILIR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILIR_ASSERT(lbl, prop, msg)
`define ILIR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/ilir_pkg.sv =====
// Types and constants of the indexed list block: request kinds, fault codes,
// request and result beats, and the command that the cells share. No dependencies.
package ilir_pkg;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_READ   = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FAULT_OK    = 2'd0,
		FAULT_RANGE = 2'd1,
		FAULT_FULL  = 2'd2
	} fault_t;

	localparam int POS_W   = 9;
	localparam int DATA_W  = 32;
	// Lanes merged in the first level of the read tree
	localparam int TREE_GROUP = 16;

	typedef struct packed {
		kind_t                     kind;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  read_value;
		logic [POS_W-1:0]          item_count;
		logic                      is_empty;
		fault_t                    fault;
	} rsp_t;

	// Broadcast to every cell: go is high for an accepted request without fault
	typedef struct packed {
		logic  go;
		kind_t kind;
	} cell_cmd_t;

endpackage

// ===== src/indexed_list_insert_remove_top.sv =====
// Top level of the indexed list: count and fault decode, the chain of entry
// cells and the read tree. Depends on ilir_pkg, ilir_cell, ilir_read_tree.
//
// Use: an ordered list of up to CAPACITY signed 32-bit entries. A request beat
// (req: kind, position, value) is taken at a rising edge with start high and
// busy low. Kinds are append, insert at position, read at position and remove
// at position. busy stays low: a request may be given in every cycle.
// Every request gives one result beat on rsp, marked by done for exactly one
// cycle: read value (zero unless a read succeeds), count after the request,
// empty flag and fault code (out of range, or full on append and insert).
// The result beat passes the two register levels of the read tree, grp_s1 then
// sum_s2, before done rises; the entry shift itself is done at the accepting
// edge, every cell taking its neighbour in parallel.
// Results leave in request order, one per request; the receiver cannot stall
// and must take each beat when done is high.
// Reset clears the count, so the list starts empty; entry values are not
// cleared and no clearing pass is run. Results in flight at reset are dropped.
`include "assert_macros.svh"

module indexed_list_insert_remove_top #(
	parameter int CAPACITY = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ilir_pkg::req_t    req,
	output logic              done,
	output ilir_pkg::rsp_t    rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic                     accept;
	logic [XW-1:0]            pos_x;
	logic [XW-1:0]            cnt_x;
	logic                     full;
	ilir_pkg::fault_t         fault_d;
	ilir_pkg::cell_cmd_t      cmd;
	logic                     req_bad;
	logic                     append_ok;

	logic                     valid_s1, valid_s2;
	logic                     rd_ok_s1, rd_ok_s2;
	logic [CW-1:0]            count_s1, count_s2;
	ilir_pkg::fault_t         fault_s1, fault_s2;

	logic [ilir_pkg::DATA_W-1:0] entry [CAPACITY];
	logic [ilir_pkg::DATA_W-1:0] lane  [CAPACITY];
	logic [ilir_pkg::DATA_W-1:0] sum_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pos_x  = XW'(req.position);
	assign cnt_x  = XW'(count_q);
	assign full   = (count_q == CAP_C);

	// Decode the fault of the request against the current count
	always_comb begin
		fault_d = ilir_pkg::FAULT_OK;
		unique case (req.kind)
			ilir_pkg::KIND_APPEND: begin
				if (full) fault_d = ilir_pkg::FAULT_FULL;
			end
			ilir_pkg::KIND_INSERT: begin
				priority if (pos_x > cnt_x) fault_d = ilir_pkg::FAULT_RANGE;
				else if (full) fault_d = ilir_pkg::FAULT_FULL;
			end
			ilir_pkg::KIND_READ,
			ilir_pkg::KIND_REMOVE: begin
				if (pos_x >= cnt_x) fault_d = ilir_pkg::FAULT_RANGE;
			end
		endcase
	end

	// Advance the count on a good append, insert or remove
	always_comb begin
		count_d = count_q;
		if (accept && fault_d == ilir_pkg::FAULT_OK) begin
			unique case (req.kind)
				ilir_pkg::KIND_APPEND,
				ilir_pkg::KIND_INSERT: count_d = count_q + CW'(1);
				ilir_pkg::KIND_REMOVE: count_d = count_q - CW'(1);
				ilir_pkg::KIND_READ:   count_d = count_q;
			endcase
		end
	end

	assign cmd.go   = accept && (fault_d == ilir_pkg::FAULT_OK);
	assign cmd.kind = req.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			count_q  <= count_d;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Carry the result side band alongside the read tree
	always_ff @(posedge clk) begin
		rd_ok_s1 <= (req.kind == ilir_pkg::KIND_READ) && (fault_d == ilir_pkg::FAULT_OK);
		count_s1 <= count_d;
		fault_s1 <= fault_d;
		rd_ok_s2 <= rd_ok_s1;
		count_s2 <= count_s1;
		fault_s2 <= fault_s1;
	end

	// Chain of entry cells, each linked to both neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ilir_pkg::DATA_W-1:0] lower_w;
		logic [ilir_pkg::DATA_W-1:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = entry[i+1];
		end
		ilir_cell #(
			.XW  (XW),
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (pos_x),
			.cnt   (cnt_x),
			.value (req.value),
			.lower (lower_w),
			.upper (upper_w),
			.entry (entry[i]),
			.lane  (lane[i])
		);
	end

	ilir_read_tree #(
		.N (CAPACITY)
	) u_read_tree (
		.clk    (clk),
		.lane   (lane),
		.sum_s2 (sum_s2)
	);

	// Drive the result beat
	assign done            = valid_s2;
	assign rsp.read_value  = rd_ok_s2 ? $signed(sum_s2) : '0;
	assign rsp.item_count  = ilir_pkg::POS_W'(count_s2);
	assign rsp.is_empty    = (count_s2 == '0);
	assign rsp.fault       = fault_s2;

	// Qualifiers for the count checks
	assign req_bad   = accept && (fault_d != ilir_pkg::FAULT_OK);
	assign append_ok = cmd.go && (req.kind == ilir_pkg::KIND_APPEND);

	`ILIR_ASSERT(a_count_cap, count_q <= CAP_C, "entry count above capacity")
	`ILIR_ASSERT(a_result_follows, valid_s1 |=> done, "request lost in result pipeline")
	`ILIR_ASSERT(a_fault_holds, req_bad |=> (count_q == $past(count_q)), "fault moved the count")
	`ILIR_ASSERT(a_grow_one, append_ok |=> (count_q == $past(count_q) + CW'(1)), "append miscount")
	`ILIR_ASSERT(a_read_zero, (done && !rd_ok_s2) |-> (rsp.read_value == '0), "data on a non-read")

endmodule

// ===== src/ilir_cell.sv =====
// One entry of the list: holds, loads or takes a neighbour's value per cycle,
// and offers its value to the read tree when addressed. Depends on ilir_pkg.
module ilir_cell #(
	parameter int XW  = 9,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  ilir_pkg::cell_cmd_t           cmd,
	input  logic [XW-1:0]                 pos,
	input  logic [XW-1:0]                 cnt,
	input  logic [ilir_pkg::DATA_W-1:0]   value,
	input  logic [ilir_pkg::DATA_W-1:0]   lower,
	input  logic [ilir_pkg::DATA_W-1:0]   upper,
	output logic [ilir_pkg::DATA_W-1:0]   entry,
	output logic [ilir_pkg::DATA_W-1:0]   lane
);

	localparam logic [XW-1:0] MY  = XW'(IDX);
	localparam logic [XW-1:0] MYP = XW'(IDX + 1);

	logic [ilir_pkg::DATA_W-1:0] entry_q;
	logic [ilir_pkg::DATA_W-1:0] entry_d;

	// Choose this cell's next value from the shared command
	always_comb begin
		entry_d = entry_q;
		if (cmd.go) begin
			unique case (cmd.kind)
				ilir_pkg::KIND_APPEND: begin
					if (MY == cnt) entry_d = value;
				end
				ilir_pkg::KIND_INSERT: begin
					priority if (MY == pos) entry_d = value;
					else if (MY > pos && MY <= cnt) entry_d = lower;
				end
				ilir_pkg::KIND_READ: begin
					entry_d = entry_q;
				end
				ilir_pkg::KIND_REMOVE: begin
					if (MY >= pos && MYP < cnt) entry_d = upper;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	// Drive the read tree only when addressed, zero otherwise
	assign lane  = (pos == MY) ? entry_q : '0;

endmodule

// ===== src/ilir_read_tree.sv =====
// Two-level registered OR tree that merges the cells' read lanes.
// Depends on ilir_pkg for the data width and group size.
module ilir_read_tree #(
	parameter int N = 256
) (
	input  logic                         clk,
	input  logic [ilir_pkg::DATA_W-1:0]  lane [N],
	output logic [ilir_pkg::DATA_W-1:0]  sum_s2
);

	localparam int GRP = ilir_pkg::TREE_GROUP;
	localparam int NG  = (N + GRP - 1) / GRP;

	logic [ilir_pkg::DATA_W-1:0] grp_d  [NG];
	logic [ilir_pkg::DATA_W-1:0] grp_s1 [NG];
	logic [ilir_pkg::DATA_W-1:0] sum_d;

	// Merge each group of lanes
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < N) grp_d[g] = grp_d[g] | lane[g * GRP + k];
			end
		end
	end

	// Merge the group results
	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NG; g++) begin
			sum_d = sum_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
		sum_s2 <= sum_d;
	end

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for the indexed list block: directed and random request beats,
// checked against an in-bench list predictor. Depends on ilir_pkg and the list top level.
module tb;
	import ilir_pkg::*;

	localparam int LIST_CAP    = 256;
	localparam int STALL_LIMIT = 1000;
	localparam int CALM_TAIL   = 150;

	typedef struct {
		req_t beat;
		bit   hold_for_drain;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Stimulus and scoreboard state
	job_t        job_q[$];
	rsp_t        expected_rsp_q[$];
	int unsigned gen_count = 0;
	int          calm_after = 0;
	int          beats_sent = 0;
	int          beats_taken = 0;
	int          errors = 0;
	int          idle_cycles = 0;
	int          gap_left = 0;
	bit          idle_phase = 1'b1;
	bit          beat_taken = 1'b0;

	// Predicted list contents
	logic signed [DATA_W-1:0] list_mem[LIST_CAP];
	int unsigned              list_len = 0;

	indexed_list_insert_remove_top #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the predicted list and return the result it should give
	function automatic rsp_t list_step(req_t r);
		rsp_t        res;
		int unsigned p;
		int unsigned i;
		res = '0;
		res.fault = FAULT_OK;
		p = 32'(r.position);
		case (r.kind)
			KIND_APPEND: begin
				if (list_len >= LIST_CAP) begin
					res.fault = FAULT_FULL;
				end else begin
					list_mem[list_len] = r.value;
					list_len++;
				end
			end
			KIND_INSERT: begin
				// range check takes priority over the full check
				if (p > list_len) begin
					res.fault = FAULT_RANGE;
				end else if (list_len >= LIST_CAP) begin
					res.fault = FAULT_FULL;
				end else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = r.value;
					list_len++;
				end
			end
			KIND_READ: begin
				if (p >= list_len) begin
					res.fault = FAULT_RANGE;
				end else begin
					res.read_value = list_mem[p];
				end
			end
			default: begin
				if (p >= list_len) begin
					res.fault = FAULT_RANGE;
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
		endcase
		res.item_count = list_len[POS_W-1:0];
		res.is_empty = (list_len == 0);
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %h, want %h (beat %0d)", field, got, want, beats_taken);
		errors++;
	endtask

	// Queue a request and track the count it leaves, to steer later stimulus
	task automatic queue_request(kind_t k, int unsigned pos, logic [31:0] v, bit drain);
		job_t j;
		j.beat.kind = k;
		j.beat.position = pos[POS_W-1:0];
		j.beat.value = v;
		j.hold_for_drain = drain;
		job_q.push_back(j);
		case (k)
			KIND_APPEND: if (gen_count < LIST_CAP) gen_count++;
			KIND_INSERT: if (pos <= gen_count && gen_count < LIST_CAP) gen_count++;
			KIND_REMOVE: if (pos < gen_count) gen_count--;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned some_index();
		return (gen_count == 0) ? 0 : $urandom_range(0, gen_count - 1);
	endfunction

	// Position that is mostly in range, sometimes anywhere in the field
	function automatic int unsigned mixed_index(bit incl_end);
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 511);
		if (incl_end)
			return $urandom_range(0, gen_count);
		return some_index();
	endfunction

	task automatic queue_noise();
		queue_request(kind_t'($urandom_range(0, 3)), $urandom_range(0, 511), $urandom, 1'b0);
	endtask

	// Sample beats at the rising edge: check results, predict accepted requests
	always @(posedge clk) begin : monitor_blk
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("unexpected result beat", 32'(rsp.item_count), '0);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", rsp.read_value, want.read_value);
					if (rsp.item_count !== want.item_count)
						report_mismatch("item_count", 32'(rsp.item_count),
							32'(want.item_count));
					if (rsp.is_empty !== want.is_empty)
						report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
					if (rsp.fault !== want.fault)
						report_mismatch("fault", 32'(rsp.fault), 32'(want.fault));
				end
			end
			beat_taken <= start && !busy;
			if (start && !busy) begin
				expected_rsp_q.push_back(list_step(req));
				beats_taken++;
			end
			// watchdog: count cycles with no beat in either direction
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Drive request beats at the falling edge, with random idle bursts
	always @(negedge clk) begin : driver_blk
		job_t nxt;
		bit   launch;
		launch = 1'b0;
		if (arst_n && (!start || beat_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (job_q.size() != 0) begin
				if (job_q[0].hold_for_drain && expected_rsp_q.size() != 0) begin
					// hold off until every result has come back
				end else if (beats_sent >= calm_after || !idle_phase
						|| $urandom_range(0, 3) != 0) begin
					launch = 1'b1;
				end else begin
					gap_left = $urandom_range(1, 16) - 1;
				end
			end
			if (launch) begin
				nxt = job_q.pop_front();
				req <= nxt.beat;
				start <= 1'b1;
				beats_sent++;
				if (beats_sent % 64 == 0)
					idle_phase = ($urandom_range(0, 2) != 0);
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin : stimulus_blk
		int          round;
		int          n;
		int unsigned r;

		// Directed: empty-list faults, extremes, ends and middle of the list
		queue_request(KIND_READ, 0, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 0, 32'h0, 1'b0);
		queue_request(KIND_INSERT, 1, 32'h1234_5678, 1'b0);
		queue_request(KIND_INSERT, 0, 32'h8000_0000, 1'b0);
		queue_request(KIND_APPEND, 511, 32'h7fff_ffff, 1'b0);
		queue_request(KIND_APPEND, 0, 32'hffff_ffff, 1'b0);
		queue_request(KIND_INSERT, 3, 32'h0000_0000, 1'b0);
		queue_request(KIND_INSERT, 1, 32'h5555_5555, 1'b0);
		queue_request(KIND_INSERT, 0, 32'haaaa_aaaa, 1'b0);
		queue_request(KIND_READ, 0, 32'h0, 1'b0);
		queue_request(KIND_READ, 5, 32'h0, 1'b0);
		queue_request(KIND_READ, 6, 32'h0, 1'b0);
		queue_request(KIND_READ, 511, 32'hffff_ffff, 1'b0);
		queue_request(KIND_READ, 256, 32'h0, 1'b0);
		queue_request(KIND_INSERT, 256, 32'h0bad_f00d, 1'b0);
		queue_request(KIND_INSERT, 8, 32'h0bad_f00d, 1'b0);
		queue_request(KIND_REMOVE, 5, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 0, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 1, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 3, 32'h0, 1'b0);
		queue_request(KIND_READ, 2, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 0, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 0, 32'h0, 1'b0);
		queue_request(KIND_REMOVE, 0, 32'h0, 1'b0);

		for (round = 0; round < 2; round++) begin
			// Grow to full, mostly appends and in-range inserts
			while (gen_count < LIST_CAP) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					queue_request(KIND_APPEND, $urandom_range(0, 511), pick_value(), 1'b0);
				else if (r < 88)
					queue_request(KIND_INSERT, $urandom_range(0, gen_count), pick_value(), 1'b0);
				else if (r < 95)
					queue_request(KIND_READ, some_index(), $urandom, 1'b0);
				else
					queue_noise();
			end
			// Full list: full faults, range priority on insert, edge reads
			queue_request(KIND_APPEND, 0, pick_value(), 1'b1);
			queue_request(KIND_INSERT, $urandom_range(0, 255), pick_value(), 1'b0);
			queue_request(KIND_INSERT, 256, pick_value(), 1'b0);
			queue_request(KIND_INSERT, $urandom_range(257, 511), pick_value(), 1'b0);
			queue_request(KIND_READ, 255, 32'h0, 1'b0);
			queue_request(KIND_READ, 256, 32'h0, 1'b0);
			queue_request(KIND_REMOVE, 256, 32'h0, 1'b0);
			queue_request(KIND_READ, 0, 32'h0, 1'b0);
			// Shrink to empty, mostly in-range removes
			while (gen_count > 0) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					queue_request(KIND_REMOVE, some_index(), $urandom, 1'b0);
				else if (r < 90)
					queue_request(KIND_READ, some_index(), $urandom, 1'b0);
				else
					queue_noise();
			end
			// Mixed traffic around a wandering count
			for (n = 0; n < 140; n++) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					queue_request(KIND_APPEND, $urandom_range(0, 511), pick_value(), n == 0);
				else if (r < 50)
					queue_request(KIND_INSERT, mixed_index(1'b1), pick_value(), n == 0);
				else if (r < 75)
					queue_request(KIND_READ, mixed_index(1'b0), $urandom, n == 0);
				else
					queue_request(KIND_REMOVE, mixed_index(1'b0), $urandom, n == 0);
			end
		end
		calm_after = job_q.size() - CALM_TAIL;
		n = job_q.size();

		// Reset once, release on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all beats to go in, then for every result to come out
		while (beats_taken < n)
			@(posedge clk);
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
